// ===== rtl/fpmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point math unit package
// Shared widths, operation codes, status codes and the divider request and reply structs.
// ----------------------------------------------------------------------------
package fpmu_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned TOL_W       = 16;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned MAX_ITERS   = 64;
   localparam int unsigned TOL_RESET   = 6;
   localparam int unsigned FLOAT_BIAS  = 134;

   // Operation selects
   localparam logic [MODE_W-1:0] OP_MUL  = 3'd0;
   localparam logic [MODE_W-1:0] OP_DIV  = 3'd1;
   localparam logic [MODE_W-1:0] OP_FLT  = 3'd2;
   localparam logic [MODE_W-1:0] OP_ABS  = 3'd3;
   localparam logic [MODE_W-1:0] OP_SQRT = 3'd4;
   localparam logic [MODE_W-1:0] OP_CBRT = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

   // Divider request and reply; the quotient carries one extra bit so that
   // a magnitude of 2^47 keeps its sign
   typedef struct packed {
      logic                start;
      logic signed [47:0]  num;
      logic signed [31:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic signed [48:0]  quo;
   } div_rsp_type;

endpackage

// ===== rtl/fpmu_div.sv =====
// ----------------------------------------------------------------------------
// Fixed-point math unit divider
// Signed 48/32 restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fpmu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fpmu_pkg::div_req_type req,
   output fpmu_pkg::div_rsp_type rsp
);

   localparam int unsigned NW = 48;

   logic [NW-1:0] quo_ff, quo_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [33:0]   trial;
   logic [32:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[NW-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      // load magnitudes
      if (req.start) begin
         quo_in  = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
         den_in  = req.den[31] ? 32'(-req.den) : 32'(req.den);
         neg_in  = req.num[NW-1] ^ req.den[31];
         rem_in  = '0;
         cnt_in  = 6'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

// ===== rtl/fpmu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fixed-point math unit sequencer
// Runs each operation, drives the shared divider and the shared multiplier.
// ----------------------------------------------------------------------------
module fpmu_ctrl #(
   parameter int unsigned MAX_ITERS = fpmu_pkg::MAX_ITERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            mode,
   input  logic signed [31:0]    op_a,
   input  logic signed [31:0]    op_b,
   input  logic [15:0]           tol,
   input  logic                  out_free,
   output logic                  idle,
   output logic                  res_valid,
   output logic signed [31:0]    res_value,
   output logic [1:0]            res_status,
   output fpmu_pkg::div_req_type div_req,
   input  fpmu_pkg::div_rsp_type div_rsp
);

   localparam int unsigned IT_W = $clog2(MAX_ITERS + 1);
   // (n * THIRD_RECIP) >> 33 is n / 3 for every 32-bit n
   localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_MUL  = 8'b00000010,
      S_DEN  = 8'b00000100,
      S_DIV  = 8'b00001000,
      S_DIFF = 8'b00010000,
      S_TRD  = 8'b00100000,
      S_STEP = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, t_ff, t_in;
   logic signed [31:0] den_ff, den_in, r_ff, r_in;
   logic [31:0]        dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic [1:0]         st_ff, st_in;
   logic               ovf_ff, ovf_in, root_ff, root_in;
   logic [IT_W-1:0]    it_ff, it_in;
   logic signed [31:0] q_sat, diff, dt, t_next;
   logic               q_ovf;
   logic [31:0]        m, mf;
   logic [8:0]         sh;
   logic signed [32:0] mul_x, mul_y;
   logic signed [65:0] mul_p;

   // saturate divider quotient
   always_comb begin
      q_ovf = 1'b0;
      q_sat = div_rsp.quo[31:0];
      if (div_rsp.quo > 49'sh7FFFFFFF) begin
         q_ovf = 1'b1;
         q_sat = 32'sh7FFFFFFF;
      end else if (div_rsp.quo < -49'sh80000000) begin
         q_ovf = 1'b1;
         q_sat = 32'sh80000000;
      end
   end

   // float bits to 16.16
   always_comb begin
      m  = {8'd0, 1'b1, op_a[22:0]};
      sh = 9'(fpmu_pkg::FLOAT_BIAS) - {1'b0, op_a[30:23]};
      if (sh[8]) mf = (-sh > 9'd31) ? '0 : m << 5'(-sh);
      else mf = (sh > 9'd31) ? '0 : m >> 5'(sh);
      if (op_a[31]) mf = -mf;
   end

   // shared multiplier: operand product, t squared, or step magnitude by 1/3
   always_comb begin
      if (state_ff == S_TRD) begin
         mul_x = {1'b0, dmag_ff};
         mul_y = {1'b0, THIRD_RECIP};
      end else if (mode_ff == fpmu_pkg::OP_MUL) begin
         mul_x = {a_ff[31], a_ff};
         mul_y = {b_ff[31], b_ff};
      end else begin
         mul_x = {t_ff[31], t_ff};
         mul_y = {t_ff[31], t_ff};
      end
      mul_p = mul_x * mul_y;
   end

   // Newton difference and signed step rebuilt from its magnitude
   always_comb begin
      diff   = r_ff - t_ff;
      dt     = dneg_ff ? -$signed(dmag_ff) : $signed(dmag_ff);
      t_next = t_ff + dt;
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      a_in = a_ff; b_in = b_ff; t_in = t_ff; den_in = den_ff; r_in = r_ff;
      dmag_in = dmag_ff; dneg_in = dneg_ff;
      st_in = st_ff; ovf_in = ovf_ff; root_in = root_ff;
      it_in = it_ff;
      div_req.start = 1'b0;
      div_req.num   = {a_ff, 16'd0};
      div_req.den   = den_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = mode; a_in = op_a; b_in = op_b;
               st_in = fpmu_pkg::ST_OK; r_in = '0; ovf_in = 1'b0;
               t_in = 32'sh00020000; it_in = '0;
               root_in = (mode == fpmu_pkg::OP_CBRT);
               case (mode) inside
                  fpmu_pkg::OP_MUL: state_in = S_MUL;
                  fpmu_pkg::OP_DIV: begin
                     den_in = op_b; state_in = S_DEN;
                  end
                  fpmu_pkg::OP_FLT: begin r_in = mf; state_in = S_DONE; end
                  fpmu_pkg::OP_ABS: begin
                     r_in = op_a[31] ? -op_a : op_a; state_in = S_DONE;
                  end
                  fpmu_pkg::OP_SQRT, fpmu_pkg::OP_CBRT: state_in = S_MUL;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            if (mode_ff == fpmu_pkg::OP_MUL) begin
               r_in = mul_p[47:16]; state_in = S_DONE;
            end else begin
               den_in = root_ff ? mul_p[47:16] : t_ff;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (den_ff == '0) begin
               st_in = fpmu_pkg::ST_DIV0;
               r_in = (mode_ff == fpmu_pkg::OP_DIV) ? '0 : t_ff;
               state_in = S_DONE;
            end else begin
               div_req.start = 1'b1; state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               r_in = q_sat;
               if (mode_ff == fpmu_pkg::OP_DIV) begin
                  if (q_ovf) st_in = fpmu_pkg::ST_OVF;
                  state_in = S_DONE;
               end else begin
                  if (q_ovf) ovf_in = 1'b1;
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            // split the difference into sign and magnitude
            dneg_in  = diff[31];
            dmag_in  = diff[31] ? 32'(-diff) : 32'(diff);
            state_in = S_TRD;
         end
         S_TRD: begin
            // halve or third the magnitude, truncating toward zero
            dmag_in  = root_ff ? {1'b0, mul_p[63:33]} : {1'b0, dmag_ff[31:1]};
            state_in = S_STEP;
         end
         S_STEP: begin
            t_in  = t_next;
            r_in  = t_next;
            it_in = it_ff + IT_W'(1);
            if (dmag_ff <= {16'd0, tol}) begin
               st_in = ovf_ff ? fpmu_pkg::ST_OVF : fpmu_pkg::ST_OK;
               state_in = S_DONE;
            end else if (it_ff == IT_W'(MAX_ITERS - 1)) begin
               st_in = fpmu_pkg::ST_LIMIT; state_in = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      mode_ff <= mode_in; a_ff <= a_in; b_ff <= b_in; t_ff <= t_in;
      den_ff <= den_in; r_ff <= r_in; st_ff <= st_in;
      dmag_ff <= dmag_in; dneg_ff <= dneg_in;
      ovf_ff <= ovf_in; root_ff <= root_in; it_ff <= it_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);
   assign res_value  = r_ff;
   assign res_status = st_ff;

endmodule

// ===== rtl/fixed_point_math_unit_top.sv =====
// ----------------------------------------------------------------------------
// Fixed-point math unit top level
// Signed 16.16 mul, div, float conversion, abs, square and cube root.
// ----------------------------------------------------------------------------
// One item at a time; req_tready stays low while an item is in progress.
// Mul, float conversion, abs and the unused modes skip the divider; div makes
// one pass of the one-bit-per-cycle divider, which a zero divisor skips. Each
// Newton iteration of a root is a divider pass plus multiply, difference,
// halve or third, and step states; a root runs at most MAX_ITERS iterations.
// A result waits in an output register while the next item is taken; a
// stalled output holds the unit in its final state.
module fixed_point_math_unit_top #(
   parameter int unsigned MAX_ITERS = fpmu_pkg::MAX_ITERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // mode[2:0], operand_a[34:3], operand_b[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result[31:0], status[33:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // root_tolerance
);

   logic [15:0]           tol_ff;
   logic                  idle, res_valid, take;
   logic signed [31:0]    res_value;
   logic [1:0]            res_status;
   logic                  ov_ff;
   logic [33:0]           od_ff;
   fpmu_pkg::div_req_type dreq;
   fpmu_pkg::div_rsp_type drsp;

   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign take       = res_valid && (!ov_ff || rsp_tready);

   // hold tolerance register
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= 16'(fpmu_pkg::TOL_RESET);
      else if (csr_valid) tol_ff <= csr_data;
   end

   fpmu_ctrl #(.MAX_ITERS(MAX_ITERS)) u_ctrl (
      .clock, .reset,
      .start(req_tvalid && idle),
      .mode(req_tdata[2:0]),
      .op_a(req_tdata[34:3]),
      .op_b(req_tdata[66:35]),
      .tol(tol_ff),
      .out_free(take),
      .idle, .res_valid, .res_value, .res_status,
      .div_req(dreq), .div_rsp(drsp)
   );

   fpmu_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   // output register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (take) ov_ff <= 1'b1;
      else if (rsp_tready) ov_ff <= 1'b0;
      if (take) od_ff <= {res_status, res_value};
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, od_ff};

endmodule

// ===== rtl/fpmu_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed-point math unit port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module fpmu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a transfer");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("padding not zero");

   a_no_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind fixed_point_math_unit_top fpmu_checker u_fpmu_checker (.*);
